// ----- src/surface_request_validator_top_assert.svh -----
// Assertion macros shared by the surface request validator modules.
`ifndef SURFACE_REQUEST_VALIDATOR_TOP_ASSERT_SVH
`define SURFACE_REQUEST_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SRV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("surface request validator: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define SRV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("surface request validator: next-cycle check failed");

`endif

// ----- src/srv_pkg.sv -----
// Package: constants, codes and controller/datapath interface types.
`default_nettype none

package srv_pkg;

    localparam int SLOT_COUNT      = 8;
    localparam int WIDTH_LIMIT     = 1024;
    localparam int HEIGHT_LIMIT    = 1024;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int WINDOW_BYTES    = 4194304;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int DIM_LIMIT  = (WIDTH_LIMIT > HEIGHT_LIMIT) ? WIDTH_LIMIT : HEIGHT_LIMIT;
    localparam int DIM_W      = $clog2(DIM_LIMIT + 1);
    localparam int BPP_W      = $clog2(BYTES_PER_PIXEL + 1);
    localparam int BYTES_W    = 32 + BPP_W;
    localparam int WIN_W      = $clog2(WINDOW_BYTES + 1);

    localparam int CMD_W     = 3;
    localparam int VER_W     = 16;
    localparam int WORD_W    = 32;
    localparam int COORD_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int OUT_DIM_W = 11;
    localparam int DIFF_W    = COORD_W + 1;

    localparam logic [WORD_W-1:0]  WINDOW_WORD  = WORD_W'(WINDOW_BYTES);
    localparam logic [COORD_W-1:0] WIDTH_WORD   = COORD_W'(WIDTH_LIMIT);
    localparam logic [COORD_W-1:0] HEIGHT_WORD  = COORD_W'(HEIGHT_LIMIT);
    localparam logic [VER_W-1:0]   VERSION_INIT = VER_W'(1);

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FLIP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_OP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_BOUNDS  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE  = 3'd5;

    typedef struct packed {
        logic                load;
        logic                ptr_clr;
        logic                ptr_inc;
        logic                set_err;
        logic [STATUS_W-1:0] err_code;
        logic                mul;
        logic                scale;
        logic                commit;
    } t_dp_cmd;

    typedef struct packed {
        logic                early_err;
        logic [STATUS_W-1:0] early_code;
        logic                hit;
        logic                ptr_last;
        logic                is_create;
        logic                out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- src/surface_request_validator_top.sv -----
// Top level: surface request validator, controller plus datapath.
`default_nettype none

// Takes one surface request word at a time and returns one response word per
// request. A request is held from acceptance until its response is loaded into
// the output register; the next request is taken the cycle after that, even if
// the response is still stalled downstream. A request rejected on version,
// opcode, create size or a spent handle counter goes from the check straight to
// the result commit. Any other request runs a slot scan from slot 0, which
// visits one slot per cycle; a hit is followed by the rectangle product, the
// byte count scaling and the result commit, and a scan that finds no slot goes
// to the result commit with an error status. The commit waits while the output
// register still holds a stalled response.
// expected_version may be rewritten only while no request is in flight.

module surface_request_validator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [srv_pkg::VER_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [srv_pkg::CMD_W-1:0]     i_command,
    input  logic [srv_pkg::VER_W-1:0]     i_req_version,
    input  logic                          i_reserved_set,
    input  logic [srv_pkg::WORD_W-1:0]    i_request_id,
    input  logic [srv_pkg::WORD_W-1:0]    i_surface_handle,
    input  logic [srv_pkg::COORD_W-1:0]   i_rect_x,
    input  logic [srv_pkg::COORD_W-1:0]   i_rect_y,
    input  logic [srv_pkg::COORD_W-1:0]   i_rect_width,
    input  logic [srv_pkg::COORD_W-1:0]   i_rect_height,
    input  logic [srv_pkg::WORD_W-1:0]    i_data_start,
    input  logic [srv_pkg::WORD_W-1:0]    i_data_size,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [srv_pkg::WORD_W-1:0]    o_echo_id,
    output logic [srv_pkg::STATUS_W-1:0]  o_status,
    output logic [srv_pkg::WORD_W-1:0]    o_result_handle,
    output logic [srv_pkg::WORD_W-1:0]    o_flip_count,
    output logic [srv_pkg::OUT_DIM_W-1:0] o_surf_width,
    output logic [srv_pkg::OUT_DIM_W-1:0] o_surf_height
);
    import srv_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    srv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    srv_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_command        (i_command),
        .i_req_version    (i_req_version),
        .i_reserved_set   (i_reserved_set),
        .i_request_id     (i_request_id),
        .i_surface_handle (i_surface_handle),
        .i_rect_x         (i_rect_x),
        .i_rect_y         (i_rect_y),
        .i_rect_width     (i_rect_width),
        .i_rect_height    (i_rect_height),
        .i_data_start     (i_data_start),
        .i_data_size      (i_data_size),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_echo_id        (o_echo_id),
        .o_status         (o_status),
        .o_result_handle  (o_result_handle),
        .o_flip_count     (o_flip_count),
        .o_surf_width     (o_surf_width),
        .o_surf_height    (o_surf_height),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts)
    );

endmodule

`default_nettype wire

// ----- src/srv_ctrl.sv -----
// Controller: sequences check, slot scan, size arithmetic and result commit.
`default_nettype none
`include "surface_request_validator_top_assert.svh"

module srv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  srv_pkg::t_dp_sts i_sts,
    output srv_pkg::t_dp_cmd o_cmd
);
    import srv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SCALE  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.early_err) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = i_sts.early_code;
                    n_state      = S_FINISH;
                end else begin
                    cmd.ptr_clr = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    n_state = S_MUL;
                end else if (i_sts.ptr_last) begin
                    cmd.set_err  = 1'b1;
                    cmd.err_code = i_sts.is_create ? ST_NO_SPACE : ST_BAD_HANDLE;
                    n_state      = S_FINISH;
                end else begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

    `SRV_ASSERT_NXT(a_accept_to_check, i_clk, i_rst_n, i_valid && !o_stall, r_state == S_CHECK)
    `SRV_ASSERT_IMP(a_commit_needs_room, i_clk, i_rst_n, o_cmd.commit, i_sts.out_free)
    `SRV_ASSERT_NXT(a_scan_miss_ends, i_clk, i_rst_n,
        r_state == S_SCAN && !i_sts.hit && i_sts.ptr_last, r_state == S_FINISH)

endmodule

`default_nettype wire

// ----- src/srv_dpath.sv -----
// Datapath: request latch, slot table, bounds arithmetic and result register.
`default_nettype none
`include "surface_request_validator_top_assert.svh"

module srv_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [srv_pkg::VER_W-1:0]        i_cfg_wr_data,
    input  logic [srv_pkg::CMD_W-1:0]        i_command,
    input  logic [srv_pkg::VER_W-1:0]        i_req_version,
    input  logic                             i_reserved_set,
    input  logic [srv_pkg::WORD_W-1:0]       i_request_id,
    input  logic [srv_pkg::WORD_W-1:0]       i_surface_handle,
    input  logic [srv_pkg::COORD_W-1:0]      i_rect_x,
    input  logic [srv_pkg::COORD_W-1:0]      i_rect_y,
    input  logic [srv_pkg::COORD_W-1:0]      i_rect_width,
    input  logic [srv_pkg::COORD_W-1:0]      i_rect_height,
    input  logic [srv_pkg::WORD_W-1:0]       i_data_start,
    input  logic [srv_pkg::WORD_W-1:0]       i_data_size,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [srv_pkg::WORD_W-1:0]       o_echo_id,
    output logic [srv_pkg::STATUS_W-1:0]     o_status,
    output logic [srv_pkg::WORD_W-1:0]       o_result_handle,
    output logic [srv_pkg::WORD_W-1:0]       o_flip_count,
    output logic [srv_pkg::OUT_DIM_W-1:0]    o_surf_width,
    output logic [srv_pkg::OUT_DIM_W-1:0]    o_surf_height,
    input  srv_pkg::t_dp_cmd                 i_cmd,
    output srv_pkg::t_dp_sts                 o_sts
);
    import srv_pkg::*;

    logic [VER_W-1:0]    r_expected_version;
    logic [WORD_W-1:0]   r_counter;

    logic [CMD_W-1:0]    r_cmd;
    logic [VER_W-1:0]    r_ver;
    logic                r_rsv;
    logic [WORD_W-1:0]   r_id;
    logic [WORD_W-1:0]   r_hnd;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic [COORD_W-1:0]  r_w;
    logic [COORD_W-1:0]  r_h;
    logic [WORD_W-1:0]   r_start;
    logic [WORD_W-1:0]   r_size;

    logic                r_err;
    logic [STATUS_W-1:0] r_err_code;
    logic [SLOT_IDX_W-1:0] r_ptr;

    logic [WORD_W-1:0]   r_slot_handle [SLOT_COUNT];
    logic [DIM_W-1:0]    r_slot_width  [SLOT_COUNT];
    logic [DIM_W-1:0]    r_slot_height [SLOT_COUNT];
    logic [WORD_W-1:0]   r_slot_flips  [SLOT_COUNT];

    logic [WORD_W-1:0]   r_s_handle;
    logic [DIM_W-1:0]    r_s_width;
    logic [DIM_W-1:0]    r_s_height;
    logic [WORD_W-1:0]   r_s_flips;
    logic [WORD_W-1:0]   r_prod;
    logic [BYTES_W-1:0]  r_bytes;
    logic [WIN_W-1:0]    r_room;
    logic                r_start_ok;

    logic                r_o_valid;
    logic [WORD_W-1:0]   r_o_echo_id;
    logic [STATUS_W-1:0] r_o_status;
    logic [WORD_W-1:0]   r_o_handle;
    logic [WORD_W-1:0]   r_o_flips;
    logic [OUT_DIM_W-1:0] r_o_width;
    logic [OUT_DIM_W-1:0] r_o_height;

    logic                is_create;
    logic                size_bad;
    logic [STATUS_W-1:0] early_code;
    logic [WORD_W-1:0]   rd_handle;
    logic                hit;
    logic [DIFF_W-1:0]   room_x;
    logic [DIFF_W-1:0]   room_y;
    logic                rect_ok;
    logic                flips_max;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_ok;
    logic                out_free;

    // Early checks, in request order
    assign is_create = (r_cmd == CMD_CREATE);
    assign size_bad  = (r_w == '0) || (r_h == '0) || (r_w > WIDTH_WORD) || (r_h > HEIGHT_WORD);

    always_comb begin
        if (r_ver != r_expected_version) begin
            early_code = ST_BAD_VERSION;
        end else if (r_rsv || (r_cmd > CMD_DESTROY)) begin
            early_code = ST_BAD_OP;
        end else if (is_create && size_bad) begin
            early_code = ST_BAD_BOUNDS;
        end else if (is_create && (r_counter == '0)) begin
            early_code = ST_NO_SPACE;
        end else begin
            early_code = ST_OK;
        end
    end

    assign rd_handle = r_slot_handle[r_ptr];
    assign hit = is_create ? (rd_handle == '0) : ((rd_handle == r_hnd) && (r_hnd != '0));

    // Rectangle and window checks on the captured slot
    assign room_x = DIFF_W'(r_s_width) - DIFF_W'(r_x);
    assign room_y = DIFF_W'(r_s_height) - DIFF_W'(r_y);
    assign rect_ok = (r_w != '0) && (r_h != '0)
                  && (DIFF_W'(r_x) <= DIFF_W'(r_s_width))
                  && (DIFF_W'(r_y) <= DIFF_W'(r_s_height))
                  && (DIFF_W'(r_w) <= room_x)
                  && (DIFF_W'(r_h) <= room_y)
                  && r_start_ok
                  && (BYTES_W'(r_size) == r_bytes)
                  && (r_bytes <= BYTES_W'(r_room));
    assign flips_max = (r_s_flips == '1);

    always_comb begin
        if (r_err) begin
            fin_status = r_err_code;
        end else begin
            unique case (r_cmd) inside
                CMD_CREATE:          fin_status = ST_OK;
                CMD_WRITE, CMD_READ: fin_status = rect_ok ? ST_OK : ST_BAD_BOUNDS;
                CMD_FLIP:            fin_status = flips_max ? ST_NO_SPACE : ST_OK;
                CMD_DESTROY:         fin_status = ST_OK;
                default:             fin_status = ST_BAD_OP;
            endcase
        end
    end
    assign fin_ok   = (fin_status == ST_OK);
    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_version <= VERSION_INIT;
        end else if (i_cfg_wr_en) begin
            r_expected_version <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_ver   <= i_req_version;
            r_rsv   <= i_reserved_set;
            r_id    <= i_request_id;
            r_hnd   <= i_surface_handle;
            r_x     <= i_rect_x;
            r_y     <= i_rect_y;
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_start <= i_data_start;
            r_size  <= i_data_size;
        end
        if (i_cmd.set_err) begin
            r_err_code <= i_cmd.err_code;
        end
        if (i_cmd.mul) begin
            r_prod     <= WORD_W'(r_w) * WORD_W'(r_h);
            r_s_handle <= rd_handle;
            r_s_width  <= r_slot_width[r_ptr];
            r_s_height <= r_slot_height[r_ptr];
            r_s_flips  <= r_slot_flips[r_ptr];
        end
        if (i_cmd.scale) begin
            r_bytes    <= BYTES_W'(r_prod) * BYTES_W'(BYTES_PER_PIXEL);
            r_start_ok <= (r_start <= WINDOW_WORD);
            r_room     <= WIN_W'(WINDOW_WORD - r_start);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err     <= 1'b0;
            r_ptr     <= '0;
            r_counter <= WORD_W'(1);
        end else begin
            if (i_cmd.load) begin
                r_err <= 1'b0;
            end else if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= r_ptr + SLOT_IDX_W'(1);
            end
            if (i_cmd.commit && fin_ok && is_create) begin
                r_counter <= r_counter + WORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_handle[i] <= '0;
            end
        end else if (i_cmd.commit && fin_ok) begin
            if (is_create) begin
                r_slot_handle[r_ptr] <= r_counter;
            end else if (r_cmd == CMD_DESTROY) begin
                r_slot_handle[r_ptr] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && fin_ok) begin
            if (is_create) begin
                r_slot_width[r_ptr]  <= DIM_W'(r_w);
                r_slot_height[r_ptr] <= DIM_W'(r_h);
                r_slot_flips[r_ptr]  <= '0;
            end else if (r_cmd == CMD_FLIP) begin
                r_slot_flips[r_ptr]  <= r_s_flips + WORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_echo_id <= r_id;
            r_o_status  <= fin_status;
            if (!fin_ok) begin
                r_o_handle <= r_hnd;
                r_o_flips  <= '0;
                r_o_width  <= '0;
                r_o_height <= '0;
            end else if (is_create) begin
                r_o_handle <= r_counter;
                r_o_flips  <= '0;
                r_o_width  <= OUT_DIM_W'(r_w);
                r_o_height <= OUT_DIM_W'(r_h);
            end else begin
                r_o_handle <= r_s_handle;
                r_o_flips  <= (r_cmd == CMD_FLIP) ? r_s_flips + WORD_W'(1) : r_s_flips;
                r_o_width  <= OUT_DIM_W'(r_s_width);
                r_o_height <= OUT_DIM_W'(r_s_height);
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.early_err  = (early_code != ST_OK);
        o_sts.early_code = early_code;
        o_sts.hit        = hit;
        o_sts.ptr_last   = (r_ptr == SLOT_IDX_W'(SLOT_COUNT - 1));
        o_sts.is_create  = is_create;
        o_sts.out_free   = out_free;
    end

    assign o_valid         = r_o_valid;
    assign o_echo_id       = r_o_echo_id;
    assign o_status        = r_o_status;
    assign o_result_handle = r_o_handle;
    assign o_flip_count    = r_o_flips;
    assign o_surf_width    = r_o_width;
    assign o_surf_height   = r_o_height;

    `SRV_ASSERT_IMP(a_result_from_commit, i_clk, i_rst_n, $rose(r_o_valid), $past(i_cmd.commit))
    `SRV_ASSERT_NXT(a_counter_stays_spent, i_clk, i_rst_n, r_counter == '0, r_counter == '0)
    `SRV_ASSERT_IMP(a_ptr_in_table, i_clk, i_rst_n, 1'b1,
        r_ptr <= SLOT_IDX_W'(SLOT_COUNT - 1))

endmodule

`default_nettype wire

// ----- verif/tb_surface_request_validator_top.sv -----
// Testbench: random and directed surface requests checked against a slot-table predictor.
`default_nettype none

module tb_surface_request_validator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srv_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int PHASE_ITEMS     = 300;
    localparam int QUIET_ITEMS     = 80;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [VER_W-1:0]   version;
        logic               reserved;
        logic [WORD_W-1:0]  request_id;
        logic [WORD_W-1:0]  surface_handle;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
        logic [WORD_W-1:0]  data_start;
        logic [WORD_W-1:0]  data_size;
    } t_surface_req;

    typedef struct packed {
        logic [WORD_W-1:0]    echo_id;
        logic [STATUS_W-1:0]  status;
        logic [WORD_W-1:0]    result_handle;
        logic [WORD_W-1:0]    flip_count;
        logic [OUT_DIM_W-1:0] surf_width;
        logic [OUT_DIM_W-1:0] surf_height;
    } t_surface_rsp;

    class surface_response_board;
        logic [VER_W-1:0]   expected_version;
        logic [WORD_W-1:0]  slot_handle [SLOT_COUNT];
        logic [COORD_W-1:0] slot_width  [SLOT_COUNT];
        logic [COORD_W-1:0] slot_height [SLOT_COUNT];
        logic [WORD_W-1:0]  slot_flips  [SLOT_COUNT];
        logic [WORD_W-1:0]  issue_handle;
        t_surface_rsp       expected_responses [$];
        int                 mismatches;
        int                 responses_checked;
        int                 status_tally [ST_BAD_HANDLE + 1];

        function new();
            expected_version = VERSION_INIT;
            foreach (slot_handle[i]) begin
                slot_handle[i] = '0;
                slot_width[i]  = '0;
                slot_height[i] = '0;
                slot_flips[i]  = '0;
            end
            issue_handle      = 1;
            mismatches        = 0;
            responses_checked = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void note_request(t_surface_req r);
            t_surface_rsp        rsp;
            logic [STATUS_W-1:0] st;
            int                  k;
            bit [63:0]           sw, sh, bytes, start;
            k  = -1;
            st = ST_OK;
            if (r.version != expected_version) begin
                st = ST_BAD_VERSION;
            end else if (r.reserved || r.command > CMD_DESTROY) begin
                st = ST_BAD_OP;
            end else if (r.command == CMD_CREATE) begin
                if (r.rect_width == 0 || r.rect_height == 0 || r.rect_width > WIDTH_WORD
                    || r.rect_height > HEIGHT_WORD) begin
                    st = ST_BAD_BOUNDS;
                end else begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                        if (slot_handle[i] == 0) k = i;
                    if (k < 0 || issue_handle == 0) begin
                        st = ST_NO_SPACE;
                        k  = -1;
                    end else begin
                        slot_handle[k] = issue_handle;
                        issue_handle   = issue_handle + 1;
                        slot_flips[k]  = '0;
                        slot_width[k]  = r.rect_width;
                        slot_height[k] = r.rect_height;
                    end
                end
            end else begin
                if (r.surface_handle != 0)
                    for (int i = SLOT_COUNT - 1; i >= 0; i--)
                        if (slot_handle[i] == r.surface_handle) k = i;
                if (k < 0) begin
                    st = ST_BAD_HANDLE;
                end else if (r.command == CMD_WRITE || r.command == CMD_READ) begin
                    sw    = slot_width[k];
                    sh    = slot_height[k];
                    start = r.data_start;
                    bytes = 64'(r.rect_width) * 64'(r.rect_height) * 64'(BYTES_PER_PIXEL);
                    if (r.rect_width == 0 || r.rect_height == 0 || r.rect_x > sw
                        || r.rect_y > sh || r.rect_width > sw - r.rect_x
                        || r.rect_height > sh - r.rect_y || start > 64'(WINDOW_BYTES)
                        || 64'(r.data_size) != bytes
                        || bytes > 64'(WINDOW_BYTES) - start) begin
                        st = ST_BAD_BOUNDS;
                        k  = -1;
                    end
                end else if (r.command == CMD_FLIP) begin
                    if (slot_flips[k] == '1) begin
                        st = ST_NO_SPACE;
                        k  = -1;
                    end else begin
                        slot_flips[k] = slot_flips[k] + 1;
                    end
                end
            end

            rsp.echo_id = r.request_id;
            rsp.status  = st;
            if (st == ST_OK && k >= 0) begin
                rsp.result_handle = slot_handle[k];
                rsp.flip_count    = slot_flips[k];
                rsp.surf_width    = slot_width[k][OUT_DIM_W-1:0];
                rsp.surf_height   = slot_height[k][OUT_DIM_W-1:0];
                if (r.command == CMD_DESTROY) slot_handle[k] = '0;
            end else begin
                rsp.result_handle = r.surface_handle;
                rsp.flip_count    = '0;
                rsp.surf_width    = '0;
                rsp.surf_height   = '0;
            end
            expected_responses.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [WORD_W-1:0] want,
                                    logic [WORD_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(t_surface_rsp got);
            t_surface_rsp want;
            if (expected_responses.size() == 0) begin
                $error("response id %0h arrived with no request outstanding", got.echo_id);
                mismatches++;
                return;
            end
            want = expected_responses.pop_front();
            responses_checked++;
            if (want.status <= ST_BAD_HANDLE) status_tally[want.status]++;
            compare_field("echo_id", want.echo_id, got.echo_id);
            compare_field("status", WORD_W'(want.status), WORD_W'(got.status));
            compare_field("result_handle", want.result_handle, got.result_handle);
            compare_field("flip_count", want.flip_count, got.flip_count);
            compare_field("surf_width", WORD_W'(want.surf_width), WORD_W'(got.surf_width));
            compare_field("surf_height", WORD_W'(want.surf_height), WORD_W'(got.surf_height));
        endfunction
    endclass

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_cfg_wr_en      = 1'b0;
    logic [VER_W-1:0]       i_cfg_wr_data    = '0;
    logic                   i_valid          = 1'b0;
    logic                   o_stall;
    logic [CMD_W-1:0]       i_command        = '0;
    logic [VER_W-1:0]       i_req_version    = '0;
    logic                   i_reserved_set   = 1'b0;
    logic [WORD_W-1:0]      i_request_id     = '0;
    logic [WORD_W-1:0]      i_surface_handle = '0;
    logic [COORD_W-1:0]     i_rect_x         = '0;
    logic [COORD_W-1:0]     i_rect_y         = '0;
    logic [COORD_W-1:0]     i_rect_width     = '0;
    logic [COORD_W-1:0]     i_rect_height    = '0;
    logic [WORD_W-1:0]      i_data_start     = '0;
    logic [WORD_W-1:0]      i_data_size      = '0;
    logic                   o_valid;
    logic                   i_stall          = 1'b0;
    logic [WORD_W-1:0]      o_echo_id;
    logic [STATUS_W-1:0]    o_status;
    logic [WORD_W-1:0]      o_result_handle;
    logic [WORD_W-1:0]      o_flip_count;
    logic [OUT_DIM_W-1:0]   o_surf_width;
    logic [OUT_DIM_W-1:0]   o_surf_height;

    t_surface_rsp          observed;
    surface_response_board board;
    bit                    idle_free        = 1'b0;
    bit                    hold_off_request = 1'b0;
    int                    requests_sent    = 0;
    int                    version_settings = 1;
    int                    quiet_cycles     = 0;

    surface_request_validator_top dut (.*);

    assign observed = {o_echo_id, o_status, o_result_handle, o_flip_count,
                       o_surf_width, o_surf_height};

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int pick_gap();
        int roll;
        if (idle_free) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] pick_extent(int limit);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return '0;
        if (roll < 8) return COORD_W'($urandom_range(limit + 1, 2**COORD_W - 1));
        if (roll < 10) return COORD_W'(limit);
        if (roll < 85) return COORD_W'($urandom_range(1, 16));
        return COORD_W'($urandom_range(1, limit));
    endfunction

    function automatic t_surface_req make_request(input logic [CMD_W-1:0] cmd,
            input logic [WORD_W-1:0] handle, input logic [COORD_W-1:0] x, y, w, h,
            input logic [WORD_W-1:0] start, size);
        t_surface_req r;
        r.command        = cmd;
        r.version        = board.expected_version;
        r.reserved       = 1'b0;
        r.request_id     = $urandom;
        r.surface_handle = handle;
        r.rect_x         = x;
        r.rect_y         = y;
        r.rect_width     = w;
        r.rect_height    = h;
        r.data_start     = start;
        r.data_size      = size;
        return r;
    endfunction

    function automatic t_surface_req surface_traffic();
        t_surface_req       r;
        int                 live_slots [$];
        int                 roll;
        int                 k;
        logic [COORD_W-1:0] sw, sh;
        int unsigned        bytes;
        r = make_request(CMD_CREATE, $urandom, COORD_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom), $urandom, $urandom);
        foreach (board.slot_handle[i])
            if (board.slot_handle[i] != 0) live_slots.push_back(i);

        if ($urandom_range(0, 99) < 12) begin
            r.command  = CMD_W'($urandom_range(0, 2**CMD_W - 1));
            r.reserved = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) r.version = VER_W'($urandom);
            if (live_slots.size() != 0 && $urandom_range(0, 1)) begin
                k = live_slots[$urandom_range(0, live_slots.size() - 1)];
                r.surface_handle = board.slot_handle[k];
            end
            return r;
        end

        roll = $urandom_range(0, 99);
        if (live_slots.size() == 0 || roll < 22) r.command = CMD_CREATE;
        else if (roll < 47) r.command = CMD_WRITE;
        else if (roll < 67) r.command = CMD_READ;
        else if (roll < 82) r.command = CMD_FLIP;
        else r.command = CMD_DESTROY;

        if (r.command == CMD_CREATE) begin
            r.rect_width  = pick_extent(WIDTH_LIMIT);
            r.rect_height = pick_extent(HEIGHT_LIMIT);
            return r;
        end

        k = live_slots[$urandom_range(0, live_slots.size() - 1)];
        r.surface_handle = board.slot_handle[k];
        roll = $urandom_range(0, 99);
        if (roll < 4) r.surface_handle = '0;
        else if (roll < 8) r.surface_handle = board.issue_handle;
        else if (roll < 12) r.surface_handle = $urandom_range(1, board.issue_handle);

        if (r.command == CMD_WRITE || r.command == CMD_READ) begin
            sw            = board.slot_width[k];
            sh            = board.slot_height[k];
            r.rect_x      = COORD_W'($urandom_range(0, sw - 1));
            r.rect_y      = COORD_W'($urandom_range(0, sh - 1));
            r.rect_width  = COORD_W'($urandom_range(1, sw - r.rect_x));
            r.rect_height = COORD_W'($urandom_range(1, sh - r.rect_y));
            bytes         = 32'(r.rect_width) * 32'(r.rect_height) * BYTES_PER_PIXEL;
            r.data_size   = bytes;
            r.data_start  = ($urandom_range(0, 3) == 0) ? WINDOW_WORD - bytes
                                                        : $urandom_range(0, WINDOW_WORD - bytes);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0: r.rect_width  = '0;
                    1: r.rect_height = '0;
                    2: r.rect_x      = sw - r.rect_width + 1'b1;
                    3: r.rect_y      = sh - r.rect_height + 1'b1;
                    4: r.data_start  = WINDOW_WORD - bytes + 1;
                    5: r.data_start  = WINDOW_WORD + $urandom_range(0, 1);
                    6: r.data_start  = $urandom_range(WINDOW_WORD + 2, 32'hFFFF_FFFF);
                    default: r.data_size = bytes ^ (32'h1 << $urandom_range(0, WORD_W - 1));
                endcase
            end
        end
        return r;
    endfunction

    task automatic send_request(input t_surface_req r, input int gap);
        i_valid          <= 1'b1;
        i_command        <= r.command;
        i_req_version    <= r.version;
        i_reserved_set   <= r.reserved;
        i_request_id     <= r.request_id;
        i_surface_handle <= r.surface_handle;
        i_rect_x         <= r.rect_x;
        i_rect_y         <= r.rect_y;
        i_rect_width     <= r.rect_width;
        i_rect_height    <= r.rect_height;
        i_data_start     <= r.data_start;
        i_data_size      <= r.data_size;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.note_request(r);
        requests_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.expected_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_version(input logic [VER_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.expected_version = v;
        version_settings++;
    endtask

    task automatic random_phase(input int items, input int quiet_items);
        for (int n = 0; n < items; n++)
            send_request(surface_traffic(), (n < quiet_items) ? 0 : pick_gap());
    endtask

    // stall the response side in random bursts, or for one long hold-off on request
    initial begin : response_sink
        int stall_run;
        @(posedge i_clk);
        forever begin
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall_run = HOLD_OFF_CYCLES;
            end else begin
                stall_run = pick_gap();
            end
            if (stall_run > 0) begin
                i_stall <= 1'b1;
                repeat (stall_run) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_response(observed);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : request_source
        t_surface_req req;
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_request(CMD_CREATE, '0, '0, '0, 16'd1, 16'd1, '0, '0), pick_gap());
        send_request(make_request(CMD_CREATE, '0, '0, '0, WIDTH_WORD, HEIGHT_WORD, '0, '0),
                     pick_gap());
        send_request(make_request(CMD_CREATE, '0, '0, '0, '0, 16'd5, '0, '0), pick_gap());
        send_request(make_request(CMD_CREATE, '0, '0, '0, WIDTH_WORD + 1'b1, 16'd1, '0, '0),
                     pick_gap());
        send_request(make_request(CMD_CREATE, '0, '0, '0, 16'd1, '1, '0, '0), pick_gap());
        send_request(make_request(CMD_WRITE, 2, '0, '0, WIDTH_WORD, HEIGHT_WORD, '0,
                                  WINDOW_WORD), pick_gap());
        send_request(make_request(CMD_READ, 1, '0, '0, 16'd1, 16'd1, WINDOW_WORD - 4, 4),
                     pick_gap());
        send_request(make_request(CMD_READ, 1, '0, '0, 16'd1, 16'd1, WINDOW_WORD, 4),
                     pick_gap());
        send_request(make_request(CMD_WRITE, 1, 16'd1, '0, 16'd1, 16'd1, '0, 4), pick_gap());
        send_request(make_request(CMD_READ, 2, '0, '0, 16'd2, 16'd2, '0, 15), pick_gap());
        send_request(make_request(CMD_FLIP, 1, '0, '0, '0, '0, '0, '0), pick_gap());
        req = make_request(CMD_FLIP, 2, '0, '0, '0, '0, '0, '0);
        req.version = ~board.expected_version;
        send_request(req, pick_gap());
        req = make_request(CMD_READ, 1, '0, '0, 16'd1, 16'd1, '0, 4);
        req.reserved = 1'b1;
        send_request(req, pick_gap());
        for (int c = CMD_DESTROY + 1; c < 2**CMD_W; c++)
            send_request(make_request(CMD_W'(c), 1, '0, '0, 16'd1, 16'd1, '0, 4), pick_gap());
        send_request(make_request(CMD_READ, '0, '0, '0, 16'd1, 16'd1, '0, 4), pick_gap());
        repeat (SLOT_COUNT - 2)
            send_request(make_request(CMD_CREATE, '0, '0, '0, 16'd2, 16'd3, '0, '0),
                         pick_gap());
        send_request(make_request(CMD_CREATE, '0, '0, '0, 16'd4, 16'd4, '0, '0), pick_gap());
        send_request(make_request(CMD_DESTROY, 1, '0, '0, '0, '0, '0, '0), pick_gap());
        send_request(make_request(CMD_FLIP, 1, '0, '0, '0, '0, '0, '0), pick_gap());
        send_request(make_request(CMD_CREATE, '0, '0, '0, 16'd7, 16'd9, '0, '0), pick_gap());

        write_version('1);
        random_phase(PHASE_ITEMS, 0);

        write_version('0);
        idle_free = 1'b1;
        random_phase(PHASE_ITEMS, 0);
        idle_free = 1'b0;

        write_version(VER_W'($urandom));
        hold_off_request = 1'b1;
        random_phase(PHASE_ITEMS, QUIET_ITEMS);

        write_version(VERSION_INIT);
        random_phase(PHASE_ITEMS, 0);

        write_version(VER_W'($urandom));
        random_phase(PHASE_ITEMS, 0);

        drain();
        $display("Sent %0d surface requests under %0d version settings; %0d responses checked.",
                 requests_sent, version_settings, board.responses_checked);
        $display("Status mix: ok %0d, version %0d, op %0d, bounds %0d, space %0d, handle %0d.",
                 board.status_tally[ST_OK], board.status_tally[ST_BAD_VERSION],
                 board.status_tally[ST_BAD_OP], board.status_tally[ST_BAD_BOUNDS],
                 board.status_tally[ST_NO_SPACE], board.status_tally[ST_BAD_HANDLE]);
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/srv_pkg.sv
src/srv_ctrl.sv
src/srv_dpath.sv
src/surface_request_validator_top.sv
verif/tb_surface_request_validator_top.sv
